### src/ldh_pkg.sv
`default_nettype none

package ldh_pkg;

	localparam int WAIT_W     = 48;
	localparam int CONF_W     = 64;
	localparam int SEL_W      = 6;
	localparam int KEY_W      = 6;
	localparam int RV_W       = 32;
	localparam int BIU_W      = 7;
	localparam int S_TDATA_W  = 184;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 40;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = 2;
	localparam int Q_CW       = 3;

	localparam logic [63:0] ONE_Q16 = 64'h0000_0000_0001_0000;
	localparam logic [BIU_W-1:0] BIU_RESET = 7'd33;

	typedef enum logic [1:0] {
		OP_STEP   = 2'd0,
		OP_RD_BIN = 2'd1,
		OP_RD_OVF = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_ZERO,
		K_BIN,
		K_OVF,
		K_RD_BIN,
		K_RD_OVF
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [KEY_W-1:0]  key;
	} cmd_t;

	typedef struct packed {
		logic              overflowed;
		logic [KEY_W-1:0]  bin_hit;
		logic              logged;
		logic [RV_W-1:0]   read_value;
	} result_t;

endpackage

`default_nettype wire

### src/ldh_front.sv
`default_nettype none

module ldh_front #(
	parameter int NUM_BINS = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_fire,
	input  wire  [ldh_pkg::S_TUSER_W-1:0]    op_in,
	input  wire  [ldh_pkg::WAIT_W-1:0]       wait_time,
	input  wire  [ldh_pkg::CONF_W-1:0]       prev_config,
	input  wire  [ldh_pkg::CONF_W-1:0]       curr_config,
	input  wire  [ldh_pkg::SEL_W-1:0]        bin_select,
	input  wire                              cfg_wr_en,
	input  wire  [ldh_pkg::BIU_W-1:0]        cfg_wr_data,
	output logic                             push,
	output ldh_pkg::cmd_t                    push_cmd
);
	import ldh_pkg::*;

	logic [63:0]       acc_q;
	logic [BIU_W-1:0]  bins_in_use_q;

	logic              valid_s1;
	op_t               op_s1;
	logic              close_s1;
	logic [63:0]       val_s1;
	logic [SEL_W-1:0]  sel_s1;

	logic [64:0]       sum;
	logic [63:0]       sat;
	logic              close;
	logic              is_step;

	logic [5:0]        msb;
	logic              pow2;
	logic [KEY_W-1:0]  key;
	logic              ov;

	assign is_step = (op_t'(op_in) == OP_STEP);
	assign sum     = {1'b0, acc_q} + 65'(wait_time);
	assign sat     = sum[64] ? {64{1'b1}} : sum[63:0];
	assign close   = (prev_config != curr_config);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			bins_in_use_q <= BIU_RESET;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= s_fire;
			if (s_fire && is_step) begin
				acc_q <= close ? 64'd0 : sat;
			end
			if (cfg_wr_en) begin
				bins_in_use_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1    <= op_t'(op_in);
			close_s1 <= is_step && close;
			val_s1   <= sat;
			sel_s1   <= bin_select;
		end
	end

	// Leading-one position and power-of-two test of the closed dwell time.
	always_comb begin
		msb = '0;
		for (int i = 0; i < 64; i++) begin
			if (val_s1[i]) begin
				msb = 6'(i);
			end
		end
	end

	assign pow2 = ((val_s1 & (val_s1 - 64'd1)) == 64'd0);

	always_comb begin
		if (val_s1 <= ONE_Q16) begin
			key = '0;
		end else if (pow2) begin
			key = msb - 6'd16;
		end else begin
			key = msb - 6'd15;
		end
	end

	assign ov = ({3'b000, key} >= {2'b00, bins_in_use_q}) ||
		(9'(key) >= 9'(NUM_BINS));

	always_comb begin
		push_cmd.kind = K_ZERO;
		push_cmd.key  = '0;
		case (op_s1)
			OP_STEP: begin
				if (close_s1) begin
					push_cmd.kind = ov ? K_OVF : K_BIN;
					push_cmd.key  = key;
				end
			end
			OP_RD_BIN: begin
				push_cmd.key = sel_s1;
				if (9'(sel_s1) < 9'(NUM_BINS)) begin
					push_cmd.kind = K_RD_BIN;
				end
			end
			OP_RD_OVF: begin
				push_cmd.kind = K_RD_OVF;
			end
			default: begin
				push_cmd.kind = K_ZERO;
			end
		endcase
	end

	assign push = valid_s1;

	a_close_clears_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && is_step && close) |=> (acc_q == 64'd0))
		else $error("accumulator not cleared after a closing step");

endmodule

`default_nettype wire

### src/ldh_queue.sv
`default_nettype none

module ldh_queue (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	input  ldh_pkg::cmd_t                push_cmd,
	input  wire                          pop,
	output ldh_pkg::cmd_t                head,
	output logic                         empty,
	output logic [ldh_pkg::Q_CW-1:0]     count
);
	import ldh_pkg::*;

	cmd_t             entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head  = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < Q_CW'(Q_DEPTH) || pop))
		else $error("command queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("command queue read while empty");

endmodule

`default_nettype wire

### src/ldh_back.sv
`default_nettype none

module ldh_back #(
	parameter int NUM_BINS   = 64,
	parameter int COUNT_BITS = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ldh_pkg::cmd_t       head,
	input  wire                 empty,
	output logic                pop,
	output logic                m_valid,
	input  wire                 m_ready,
	output ldh_pkg::result_t    m_result
);
	import ldh_pkg::*;

	localparam int AW = $clog2(NUM_BINS);

	logic [COUNT_BITS-1:0]  mem_q [NUM_BINS];
	logic [NUM_BINS-1:0]    vld_q;
	logic [COUNT_BITS-1:0]  ovf_q;

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	logic [COUNT_BITS-1:0]  rdata_s1;
	logic                   rvld_s1;
	logic                   fwd_s1;
	logic [COUNT_BITS-1:0]  fwd_data_s1;

	logic                   m_valid_q;
	result_t                result_q;
	result_t                res;

	logic                   fire;
	logic [AW-1:0]          head_addr;
	logic [AW-1:0]          wr_addr;
	logic                   wr_en;
	logic [COUNT_BITS-1:0]  cur;
	logic [COUNT_BITS-1:0]  wr_data;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
	endfunction

	function automatic logic [RV_W-1:0] clip32(input logic [COUNT_BITS-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'h0000_0000_FFFF_FFFF) ? {RV_W{1'b1}} : w[RV_W-1:0];
	endfunction

	assign fire      = valid_s1 && (!m_valid_q || m_ready);
	assign pop       = !empty && (!valid_s1 || fire);
	assign head_addr = AW'(head.key);
	assign wr_addr   = AW'(cmd_s1.key);
	assign wr_en     = fire && (cmd_s1.kind == K_BIN);

	// A bin written in the same cycle as its read is taken from the write data.
	assign cur     = fwd_s1 ? fwd_data_s1 : (rvld_s1 ? rdata_s1 : '0);
	assign wr_data = sat_inc(cur);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (pop) begin
			rdata_s1    <= mem_q[head_addr];
			cmd_s1      <= head;
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			ovf_q    <= '0;
			valid_s1 <= 1'b0;
			rvld_s1  <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (fire && cmd_s1.kind == K_OVF) begin
				ovf_q <= sat_inc(ovf_q);
			end
			if (pop) begin
				valid_s1 <= 1'b1;
				rvld_s1  <= vld_q[head_addr];
				fwd_s1   <= wr_en && (wr_addr == head_addr);
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		res = '0;
		case (cmd_s1.kind)
			K_BIN: begin
				res.logged  = 1'b1;
				res.bin_hit = cmd_s1.key;
			end
			K_OVF: begin
				res.logged     = 1'b1;
				res.overflowed = 1'b1;
			end
			K_RD_BIN: begin
				res.read_value = clip32(cur);
			end
			K_RD_OVF: begin
				res.read_value = clip32(ovf_q);
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= res;
		end
	end

	assign m_valid  = m_valid_q;
	assign m_result = result_q;

	a_ovf_only_on_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ovf_q) |-> $past(fire && cmd_s1.kind == K_OVF))
		else $error("overflow count changed without an overflow command");

endmodule

`default_nettype wire

### src/log2_dwell_time_histogram_core.sv
`default_nettype none

// Channel  | Direction | Payload
// s_axis   | in        | tuser: op; tdata: wait_time, prev_config, curr_config, bin_select
// m_axis   | out       | tdata: read_value, logged, bin_hit, overflowed
// cfg      | in        | cfg_wr_data: bins_in_use, written when cfg_wr_en is high
//
// One item per cycle unless the output stalls; items cross front stage, queue, back stage.
// The bin store is a single-port-read memory whose read-modify-write is forwarded,
// so back-to-back hits on one bin need no stall.
// Reset clears every bin at once through per-bin valid bits; there is no clearing pass.
// A stalled output holds the back stage, then fills a four-entry command queue;
// s_axis_tready drops when the queue plus the front stage would exceed four entries.

module log2_dwell_time_histogram_core #(
	parameter int NUM_BINS   = 64,
	parameter int COUNT_BITS = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// wait_time[47:0], prev_config[111:48], curr_config[175:112], bin_select[181:176]
	input  wire  [ldh_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// op[1:0]
	input  wire  [ldh_pkg::S_TUSER_W-1:0]      s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// read_value[31:0], logged[32], bin_hit[38:33], overflowed[39]
	output logic [ldh_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	input  wire                                cfg_wr_en,
	input  wire  [ldh_pkg::BIU_W-1:0]          cfg_wr_data
);
	import ldh_pkg::*;

	logic             s_fire;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	cmd_t             head;
	logic             empty;
	logic [Q_CW-1:0]  count;
	result_t          m_result;

	// The front stage holds at most one item, so credit it against the queue.
	assign s_axis_tready = ((count + Q_CW'(push)) < Q_CW'(Q_DEPTH));
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	ldh_front #(
		.NUM_BINS(NUM_BINS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_fire      (s_fire),
		.op_in       (s_axis_tuser),
		.wait_time   (s_axis_tdata[47:0]),
		.prev_config (s_axis_tdata[111:48]),
		.curr_config (s_axis_tdata[175:112]),
		.bin_select  (s_axis_tdata[181:176]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	ldh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (count)
	);

	ldh_back #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_result (m_result)
	);

	assign m_axis_tdata = m_result;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

class dwell_hist_scoreboard;
	localparam int BINS = 64;

	bit [63:0] dwell_acc;
	bit [31:0] bin_count [BINS];
	bit [31:0] ovf_count;
	bit [6:0]  bins_in_use;
	bit [63:0] bins_hit;
	ldh_pkg::result_t expected_results [$];
	int mismatches;
	int results_checked;
	int intervals_closed;
	int overflow_hits;

	function new();
		dwell_acc = '0;
		foreach (bin_count[i]) bin_count[i] = '0;
		ovf_count = '0;
		bins_in_use = ldh_pkg::BIU_RESET;
		bins_hit = '0;
	endfunction

	// ceil(log2(v)) for a Q48.16 value, with everything up to 1.0 in bin zero.
	static function int unsigned log2_key(bit [63:0] v);
		int unsigned msb;
		msb = 0;
		if (v <= ldh_pkg::ONE_Q16)
			return 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) msb = i;
		return ((v & (v - 64'd1)) == 64'd0) ? msb - 16 : msb - 15;
	endfunction

	function void note_item(ldh_pkg::op_t op, bit [47:0] wt, bit [63:0] prev,
			bit [63:0] curr, bit [5:0] sel);
		ldh_pkg::result_t r;
		bit [64:0] sum;
		int unsigned key;
		int unsigned lim;
		r = '0;
		case (op)
		ldh_pkg::OP_STEP: begin
			sum = {1'b0, dwell_acc} + {17'd0, wt};
			dwell_acc = sum[64] ? '1 : sum[63:0];
			if (prev != curr) begin
				key = log2_key(dwell_acc);
				lim = (bins_in_use > BINS) ? BINS : bins_in_use;
				dwell_acc = '0;
				r.logged = 1'b1;
				intervals_closed++;
				if (key >= lim) begin
					r.overflowed = 1'b1;
					overflow_hits++;
					if (ovf_count != '1) ovf_count++;
				end else begin
					if (bin_count[key] != '1) bin_count[key]++;
					r.bin_hit = key[5:0];
					bins_hit[key] = 1'b1;
				end
			end
		end
		ldh_pkg::OP_RD_BIN: r.read_value = bin_count[sel];
		ldh_pkg::OP_RD_OVF: r.read_value = ovf_count;
		default: ;
		endcase
		expected_results = {expected_results, r};
	endfunction

	function void flag(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH at %0t: %s", $time, msg);
	endfunction

	function void check_result(ldh_pkg::result_t got);
		ldh_pkg::result_t want;
		if (expected_results.size() == 0) begin
			flag($sformatf("result %h arrived with nothing outstanding", got));
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		if (got.read_value !== want.read_value || got.logged !== want.logged ||
				got.bin_hit !== want.bin_hit || got.overflowed !== want.overflowed)
			flag($sformatf({"read_value exp %h got %h, logged exp %b got %b, ",
				"bin_hit exp %0d got %0d, overflowed exp %b got %b"},
				want.read_value, got.read_value, want.logged, got.logged,
				want.bin_hit, got.bin_hit, want.overflowed, got.overflowed));
	endfunction
endclass

module tb_top;
	import ldh_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic cfg_wr_en;
	logic [BIU_W-1:0] cfg_wr_data;

	dwell_hist_scoreboard sb;
	bit no_idle;
	int tx_calm;
	int unsigned cycle_count = 0;

	log2_dwell_time_histogram_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, sb.expected_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(result_t'(m_axis_tdata));

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int next_gap();
		if (no_idle)
			return 0;
		if (tx_calm > 0) begin
			tx_calm--;
			return 0;
		end
		if ($urandom_range(0, 99) < 4) begin
			tx_calm = $urandom_range(20, 80);
			return 0;
		end
		return idle_len();
	endfunction

	// Result side: alternating stalls and ready stretches, some of them long.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left == 0 && hold_left == 0) begin
				stall_left = no_idle ? 0 : idle_len();
				hold_left = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150)
					: $urandom_range(1, 12);
			end
			if (stall_left > 0 && !no_idle) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (hold_left > 0) hold_left--;
			end
		end
	end

	// Entered and left at a falling edge; valid stays high for a following item.
	task automatic send_item(op_t op, bit [47:0] wt, bit [63:0] prev, bit [63:0] curr,
			bit [5:0] sel);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'b00, sel, curr, prev, wt};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_item(op, wt, prev, curr, sel);
		@(negedge clk);
	endtask

	task automatic step_item(bit [47:0] wt, bit closes);
		send_item(OP_STEP, wt, 64'd0, closes ? '1 : 64'd0, 6'd0);
	endtask

	task automatic random_phase(int n);
		op_t op;
		bit [47:0] wt;
		bit [63:0] prev;
		bit [63:0] curr;
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			op = (r < 72) ? OP_STEP : (r < 86) ? OP_RD_BIN : (r < 96) ? OP_RD_OVF : OP_NONE;
			case ($urandom_range(0, 9))
			0: wt = '0;
			1: wt = 48'({$urandom, $urandom});
			2: wt = 48'd1 << $urandom_range(0, 47);
			3: wt = 48'h10000 + 48'($urandom_range(0, 2)) - 48'd1;
			default: wt = 48'({$urandom, $urandom} >> $urandom_range(16, 63));
			endcase
			prev = {$urandom, $urandom};
			r = $urandom_range(0, 99);
			// Most steps stay in the same configuration so that dwell time builds up.
			curr = (r < 70) ? prev : (r < 80) ? prev ^ (64'd1 << $urandom_range(0, 63))
				: {$urandom, $urandom};
			send_item(op, wt, prev, curr, 6'($urandom_range(0, 63)));
		end
	endtask

	task automatic read_back();
		for (int i = 0; i < 64; i++)
			send_item(OP_RD_BIN, 48'({$urandom, $urandom}), {$urandom, $urandom},
				{$urandom, $urandom}, 6'(i));
		send_item(OP_RD_OVF, 48'({$urandom, $urandom}), {$urandom, $urandom},
			{$urandom, $urandom}, 6'($urandom_range(0, 63)));
	endtask

	initial begin
		bit [6:0] biu_plan [7];
		sb = new();
		no_idle = 1'b0;
		tx_calm = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		biu_plan = '{7'd0, 7'd1, 7'd127, 7'd64, 7'd65,
			7'($urandom_range(2, 63)), 7'($urandom_range(0, 127))};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items under the reset setting of 33 bins.
		send_item(OP_RD_OVF, '0, '0, '0, 6'd0);
		send_item(OP_RD_BIN, '1, '1, '1, 6'd0);
		send_item(OP_RD_BIN, '0, '1, '0, 6'd63);
		send_item(OP_STEP, '0, '1, '1, 6'd63);
		step_item(48'd0, 1'b1);
		step_item(48'h1_0000, 1'b1);
		step_item(48'h1_0001, 1'b1);
		step_item(48'h2_0000, 1'b1);
		step_item(48'h2_0001, 1'b1);
		step_item('1, 1'b1);
		step_item('1, 1'b0);
		step_item('1, 1'b1);
		send_item(OP_NONE, '1, '1, '0, 6'd63);
		send_item(OP_RD_BIN, '0, '0, '0, 6'd32);
		send_item(OP_RD_BIN, '0, '0, '0, 6'd1);
		send_item(OP_RD_OVF, '0, '0, '0, 6'd0);
		random_phase(130);
		read_back();

		foreach (biu_plan[i]) begin
			// Register writes only with the pipeline drained.
			s_axis_tvalid <= 1'b0;
			while (sb.expected_results.size() != 0) @(negedge clk);
			repeat (4) @(negedge clk);
			cfg_wr_data <= biu_plan[i];
			cfg_wr_en <= 1'b1;
			@(negedge clk);
			cfg_wr_en <= 1'b0;
			sb.bins_in_use = biu_plan[i];
			random_phase(130);
			read_back();
		end

		s_axis_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Checked %0d results; %0d dwell intervals closed, %0d of them as overflow.",
			sb.results_checked, sb.intervals_closed, sb.overflow_hits);
		$display("%0d distinct bins hit over eight bins_in_use settings.",
			$countones(sb.bins_hit));
		if (sb.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### filelist.f
src/ldh_pkg.sv
src/ldh_front.sv
src/ldh_queue.sv
src/ldh_back.sv
src/log2_dwell_time_histogram_core.sv
test/tb_top.sv
